FILE: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // Field widths
  localparam int ADDR_W = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int NIB_W  = 4;

  // Configuration port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FOREGROUND = 1'b1;

  localparam logic [NIB_W-1:0] BACKGROUND_RESET = 4'h0;
  localparam logic [NIB_W-1:0] FOREGROUND_RESET = 4'h7;

  // Item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;

  // Frequently used addresses
  localparam logic [ADDR_W-1:0] CELLS_A         = ADDR_W'(CELLS);
  localparam logic [ADDR_W-1:0] LAST_CELL_A     = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COLUMNS_A       = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE_A = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW        = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL        = COL_W'(COLUMNS - 1);

  // Screen memory access, one write and one read port
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: design/tcw_cfg_regs.sv
// ----------------------------------------------------------------------------
// tcw_cfg_regs
// APB register file holding the background and foreground color nibbles.
// ----------------------------------------------------------------------------
module tcw_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]  paddr,
  input  logic [tcw_pkg::APB_DW-1:0]  pwdata,
  output logic [tcw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [tcw_pkg::ATTR_W-1:0]  attr
);
  import tcw_pkg::*;

  logic [NIB_W-1:0]     background_r;
  logic [NIB_W-1:0]     foreground_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      background_r <= BACKGROUND_RESET;
      foreground_r <= FOREGROUND_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BACKGROUND: background_r <= pwdata[NIB_W-1:0];
        REG_FOREGROUND: foreground_r <= pwdata[NIB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BACKGROUND: prdata = {{(APB_DW-NIB_W){1'b0}}, background_r};
      REG_FOREGROUND: prdata = {{(APB_DW-NIB_W){1'b0}}, foreground_r};
      default:        prdata = '0;
    endcase
  end

  assign attr = {background_r, foreground_r};

endmodule

FILE: design/tcw_screen_mem.sv
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem (
  input  logic                       clk,
  input  tcw_pkg::mem_req_t          req,
  output logic [tcw_pkg::CELL_W-1:0] rdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] cells [CELLS];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= cells[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console: cursor control, scroll sequencer and result
// buffering around a single screen memory.
// ----------------------------------------------------------------------------
// All cells live in one memory with one write and one read port. After reset a
// clearing pass writes every cell and no item is taken meanwhile; configuration
// writes are accepted. A put of an ordinary character, and a newline that is
// not on the last row, needs no state beyond S_IDLE. A read passes through
// S_READ because of the memory's registered read. A newline on the last row
// scrolls: the memory copies one cell per cycle through its read and write
// ports, then S_DRAIN writes the last copied cell and S_FILL fills the bottom
// row with spaces, with input stalled. A result register plus a one-entry
// holding register let a finished result wait on out_stall without losing the
// next one.
module text_console_writer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_character,
  input  logic [tcw_pkg::ADDR_W-1:0]  in_cell_address,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcw_pkg::CELL_W-1:0]  out_read_data,
  output logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tcw_pkg::COL_W-1:0]   out_cursor_column,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]  paddr,
  input  logic [tcw_pkg::APB_DW-1:0]  pwdata,
  output logic [tcw_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_COPY,
    S_DRAIN,
    S_FILL
  } state_t;

  state_t            state_r;
  logic [ADDR_W-1:0] scan_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic              copy_pend_r;
  logic              rd_oob_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic [ADDR_W-1:0] pos_r;

  logic              out_valid_r;
  logic [CELL_W-1:0] out_data_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              pend_valid_r;
  logic [CELL_W-1:0] pend_data_r;
  logic [ROW_W-1:0]  pend_row_r;
  logic [COL_W-1:0]  pend_col_r;

  logic [ATTR_W-1:0] attr;
  logic [CELL_W-1:0] rdata;
  mem_req_t          mem_req;

  logic              accept;
  logic              is_newline;
  logic              do_scroll;
  logic [ROW_W-1:0]  row_nxt;
  logic [COL_W-1:0]  col_nxt;
  logic [ADDR_W-1:0] pos_nxt;
  logic              res_valid;
  logic [CELL_W-1:0] res_data;
  logic [ROW_W-1:0]  res_row;
  logic [COL_W-1:0]  res_col;
  logic              slot_free;

  tcw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr    (attr)
  );

  tcw_screen_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  assign in_stall   = (state_r != S_IDLE) || pend_valid_r;
  assign accept     = in_valid && !in_stall;
  assign is_newline = (in_character == NEWLINE_CHAR);
  assign do_scroll  = accept && (in_kind == KIND_PUT) && is_newline && (row_r == LAST_ROW);
  assign slot_free  = !out_valid_r || !out_stall;

  // Cursor update for a put; pos_r tracks row*COLUMNS+col incrementally
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    pos_nxt = pos_r;
    if (is_newline) begin
      col_nxt = '0;
      if (row_r != LAST_ROW) begin
        row_nxt = row_r + ROW_W'(1);
        pos_nxt = pos_r - ADDR_W'(col_r) + COLUMNS_A;
      end else begin
        pos_nxt = LAST_ROW_BASE_A;
      end
    end else if (col_r == LAST_COL) begin
      col_nxt = '0;
      if (row_r != LAST_ROW) begin
        row_nxt = row_r + ROW_W'(1);
        pos_nxt = pos_r + ADDR_W'(1);
      end else begin
        // wrap on the last row stays on it without scrolling
        pos_nxt = LAST_ROW_BASE_A;
      end
    end else begin
      col_nxt = col_r + COL_W'(1);
      pos_nxt = pos_r + ADDR_W'(1);
    end
  end

  // Memory requests
  always_comb begin
    mem_req = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = scan_r;
        mem_req.wdata = RESET_CELL;
      end
      S_IDLE: begin
        if (accept && (in_kind == KIND_PUT) && !is_newline) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pos_r;
          mem_req.wdata = {attr, in_character};
        end
        if (accept && (in_kind == KIND_READ) && (in_cell_address < CELLS_A)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = in_cell_address;
        end
      end
      S_COPY: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = scan_r;
        mem_req.we    = copy_pend_r;
        mem_req.waddr = wr_addr_r;
        mem_req.wdata = rdata;
      end
      S_DRAIN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wr_addr_r;
        mem_req.wdata = rdata;
      end
      S_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = scan_r;
        mem_req.wdata = {attr, SPACE_CHAR};
      end
      S_READ: ;
      default: ;
    endcase
  end

  // Finished result of the current transaction, if any
  always_comb begin
    res_valid = 1'b0;
    res_data  = '0;
    res_row   = row_r;
    res_col   = col_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == KIND_PUT) && !do_scroll) begin
          res_valid = 1'b1;
          res_row   = row_nxt;
          res_col   = col_nxt;
        end
      end
      S_READ: begin
        res_valid = 1'b1;
        res_data  = rd_oob_r ? '0 : rdata;
      end
      S_FILL: begin
        res_valid = (scan_r == LAST_CELL_A);
      end
      S_CLEAR, S_COPY, S_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      scan_r       <= '0;
      copy_pend_r  <= 1'b0;
      row_r        <= LAST_ROW;
      col_r        <= '0;
      pos_r        <= LAST_ROW_BASE_A;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          scan_r <= scan_r + ADDR_W'(1);
          if (scan_r == LAST_CELL_A) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (in_kind == KIND_READ) begin
              rd_oob_r <= (in_cell_address >= CELLS_A);
              state_r  <= S_READ;
            end else begin
              row_r <= row_nxt;
              col_r <= col_nxt;
              pos_r <= pos_nxt;
              if (do_scroll) begin
                scan_r      <= COLUMNS_A;
                copy_pend_r <= 1'b0;
                state_r     <= S_COPY;
              end
            end
          end
        end
        S_READ: begin
          state_r <= S_IDLE;
        end
        S_COPY: begin
          // read cell scan_r now, write it one row up next cycle
          copy_pend_r <= 1'b1;
          wr_addr_r   <= scan_r - COLUMNS_A;
          scan_r      <= scan_r + ADDR_W'(1);
          if (scan_r == LAST_CELL_A) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          scan_r  <= LAST_ROW_BASE_A;
          state_r <= S_FILL;
        end
        S_FILL: begin
          scan_r <= scan_r + ADDR_W'(1);
          if (scan_r == LAST_CELL_A) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // result register with a one-entry holding stage
      if (pend_valid_r) begin
        if (slot_free) begin
          out_valid_r  <= 1'b1;
          out_data_r   <= pend_data_r;
          out_row_r    <= pend_row_r;
          out_col_r    <= pend_col_r;
          pend_valid_r <= 1'b0;
        end
      end else if (res_valid) begin
        if (slot_free) begin
          out_valid_r <= 1'b1;
          out_data_r  <= res_data;
          out_row_r   <= res_row;
          out_col_r   <= res_col;
        end else begin
          pend_valid_r <= 1'b1;
          pend_data_r  <= res_data;
          pend_row_r   <= res_row;
          pend_col_r   <= res_col;
        end
      end else if (slot_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_data_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;

  // The holding stage only fills behind a stalled result
  a_pend_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("holding stage full with empty result register");

  // Cursor address stays consistent with row and column
  a_pos_consistent : assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == ADDR_W'(32'(row_r) * COLUMNS + 32'(col_r))) &&
    (row_r <= LAST_ROW) && (col_r <= LAST_COL))
    else $error("cursor address out of step with row and column");

  // Scroll copy never writes the cell it reads in the same cycle
  a_copy_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("screen memory read and write collide");

  // A scrolling newline produces its result only when the fill ends
  a_scroll_result : assert property (@(posedge clk) disable iff (!rst_n)
    do_scroll |=> (state_r == S_COPY) && !res_valid)
    else $error("scroll did not start its copy pass");

endmodule
